FILE: rtl/irla_pkg.sv
// ----------------------------------------------------------------------------
// irla_pkg
// Shared widths, register defaults, codes and types of the infrared range
// averaging and linearization block.
// ----------------------------------------------------------------------------
package irla_pkg;

  localparam int SAMPLE_W        = 10;
  localparam int NUM_W           = 16;
  localparam int OFF_W           = 10;
  localparam int ROFF_W          = 8;
  localparam int DIST_W          = 17;
  localparam int AVG_W           = 10;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  localparam int AVG_SHIFT_DEF   = 3;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam logic [NUM_W-1:0]  NUMERATOR_RST  = 16'd6787;
  localparam logic [OFF_W-1:0]  DIV_OFFSET_RST = 10'd3;
  localparam logic [ROFF_W-1:0] RES_OFFSET_RST = 8'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUMERATOR  = 2'd0,
    CFG_DIV_OFFSET = 2'd1,
    CFG_RES_OFFSET = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [OFF_W-1:0] divisor;
  } div_ctl_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

endpackage

FILE: rtl/irla_if.sv
// ----------------------------------------------------------------------------
// irla_if
// Valid/ready request channels for raw samples and for distance results.
// ----------------------------------------------------------------------------
interface irla_in_if;
  logic                           valid;
  logic                           ready;
  logic [irla_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface irla_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [irla_pkg::DIST_W-1:0] distance;
  logic [irla_pkg::AVG_W-1:0]       average;
  logic                             out_of_range;

  modport source (output valid, output distance, output average, output out_of_range,
                  input ready);
  modport sink   (input valid, input distance, input average, input out_of_range,
                  output ready);
endinterface

FILE: rtl/irla_div.sv
// ----------------------------------------------------------------------------
// irla_div
// Bit-serial restoring divider: the dividend shifts out one bit per cycle
// and one quotient bit shifts in.
// ----------------------------------------------------------------------------
module irla_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  irla_pkg::div_ctl_t        ctl,
  output irla_pkg::div_sts_t        sts,
  output logic [irla_pkg::NUM_W-1:0] quotient
);
  import irla_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [OFF_W:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [OFF_W-1:0] den_r, den_nxt;
  logic [OFF_W:0]   shifted;
  logic [OFF_W+1:0] trial;
  logic             fits;

  always_comb begin
    shifted  = {rem_r[OFF_W-1:0], quo_r[NUM_W-1]};
    trial    = {1'b0, shifted} - {2'b00, den_r};
    fits     = ~trial[OFF_W+1];
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = ctl.dividend;
      den_nxt  = ctl.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[OFF_W:0] : shifted;
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/ir_range_average_and_linearize.sv
// A sample that does not close a block is taken while ready stays high.
// The last sample of a block sets the average, which is checked against the divisor
// offset; the divider runs unless the average is at or below that offset, and the
// result is then registered once the output is free. No sample is taken meanwhile.
// Synchronous active-low reset clears the sum, the count and the output valid, and
// loads the register defaults.
// ----------------------------------------------------------------------------
// ir_range_average_and_linearize
// Block averaging of sensor samples and reciprocal conversion to distance.
// ----------------------------------------------------------------------------
module ir_range_average_and_linearize #(
  parameter int AVG_SHIFT   = irla_pkg::AVG_SHIFT_DEF,
  parameter int SAMPLE_BITS = irla_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [irla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irla_pkg::CFG_DATA_W-1:0] cfg_wdata,
  irla_in_if.sink                         in_ch,
  irla_out_if.source                      out_ch
);
  import irla_pkg::*;

  localparam int SUM_W     = SAMPLE_BITS + AVG_SHIFT;
  localparam int CNT_W     = (AVG_SHIFT > 0) ? AVG_SHIFT : 1;
  localparam int BLOCK_LEN = 1 << AVG_SHIFT;

  state_t              state_r, state_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [AVG_W-1:0]    avg_r, avg_nxt;
  logic                flag_r, flag_nxt;
  logic [NUM_W-1:0]    numerator_r;
  logic [OFF_W-1:0]    div_offset_r;
  logic [ROFF_W-1:0]   res_offset_r;
  logic                out_valid_r, out_valid_nxt;
  logic signed [DIST_W-1:0] dist_r, dist_nxt;
  logic [AVG_W-1:0]    out_avg_r, out_avg_nxt;
  logic                out_flag_r, out_flag_nxt;

  logic [SUM_W-1:0]    sample_ext;
  logic [SUM_W-1:0]    sum_add;
  logic [SUM_W-1:0]    avg_full;
  logic                accept;
  logic                block_end;
  logic [OFF_W:0]      avg_diff;
  div_ctl_t            div_ctl;
  div_sts_t            div_sts;
  logic [NUM_W-1:0]    quotient;

  irla_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .sts      (div_sts),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      numerator_r  <= NUMERATOR_RST;
      div_offset_r <= DIV_OFFSET_RST;
      res_offset_r <= RES_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUMERATOR:  numerator_r  <= cfg_wdata[NUM_W-1:0];
        CFG_DIV_OFFSET: div_offset_r <= cfg_wdata[OFF_W-1:0];
        CFG_RES_OFFSET: res_offset_r <= cfg_wdata[ROFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sample_ext = SUM_W'(in_ch.sample) & SUM_W'({SAMPLE_BITS{1'b1}});
    sum_add    = sum_r + sample_ext;
    avg_full   = sum_add >> AVG_SHIFT;
    accept     = in_ch.valid && in_ch.ready;
    block_end  = (count_r == CNT_W'(BLOCK_LEN - 1));
    avg_diff   = {1'b0, avg_r} - {1'b0, div_offset_r};

    state_nxt        = state_r;
    sum_nxt          = sum_r;
    count_nxt        = count_r;
    avg_nxt          = avg_r;
    flag_nxt         = flag_r;
    out_valid_nxt    = out_valid_r;
    dist_nxt         = dist_r;
    out_avg_nxt      = out_avg_r;
    out_flag_nxt     = out_flag_r;
    div_ctl.start    = 1'b0;
    div_ctl.dividend = numerator_r;
    div_ctl.divisor  = avg_diff[OFF_W-1:0];
    in_ch.ready      = (state_r == ST_IDLE);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (block_end) begin
            sum_nxt   = '0;
            count_nxt = '0;
            avg_nxt   = AVG_W'(avg_full);
            state_nxt = ST_CHECK;
          end else begin
            sum_nxt   = sum_add;
            count_nxt = count_r + 1'b1;
          end
        end
      end
      ST_CHECK: begin
        flag_nxt = (avg_r <= div_offset_r);
        if (avg_r <= div_offset_r) begin
          state_nxt = ST_DONE;
        end else begin
          div_ctl.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = avg_r;
          out_flag_nxt  = flag_r;
          dist_nxt      = flag_r ? '0 :
                          $signed({1'b0, quotient} - {{(DIST_W-ROFF_W){1'b0}}, res_offset_r});
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    avg_r      <= avg_nxt;
    flag_r     <= flag_nxt;
    dist_r     <= dist_nxt;
    out_avg_r  <= out_avg_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.distance     = dist_r;
  assign out_ch.average      = out_avg_r;
  assign out_ch.out_of_range = out_flag_r;

endmodule

FILE: rtl/irla_check.sv
// ----------------------------------------------------------------------------
// irla_check
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module irla_check (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [irla_pkg::DIST_W-1:0]  out_distance,
  input logic [irla_pkg::AVG_W-1:0]          out_average,
  input logic                                out_out_of_range
);
  import irla_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result request is valid right after reset.");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_distance == '0)
    else $error("Out-of-range result carries a nonzero distance.");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result request dropped before it was taken.");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_distance) && $stable(out_average) &&
    $stable(out_out_of_range))
    else $error("Stalled result request changed its payload.");

endmodule

bind ir_range_average_and_linearize irla_check u_irla_check (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_distance     (out_ch.distance),
  .out_average      (out_ch.average),
  .out_out_of_range (out_ch.out_of_range)
);
